[hdl/fia_pkg.sv]
// Shared constants, types and an elaboration-time log2 function for the
// fuzziness index accumulator. No dependencies.
`timescale 1ns / 1ps

package fia_pkg;

  // Sizes fixed by the block's fields
  localparam int VOXEL_W           = 16;
  localparam int COUNT_BITS        = 32;
  localparam int ENTROPY_FRAC_BITS = 16;
  localparam int ENT_W             = ENTROPY_FRAC_BITS;
  localparam int SUPPORT_W         = 32;
  localparam int ENTROPY_W         = 48;
  localparam int DIST_W            = 47;
  localparam int SQUARE_W          = 62;
  localparam int SQUARE_ACC_W      = 63;
  localparam int HALF_W            = 15;  // min(v, full - v) never exceeds 32767
  localparam int HALF_SQ_W         = 2 * HALF_W;

  // Membership full scale
  localparam logic [VOXEL_W-1:0] FULL_SCALE = 16'd65534;

  // Fixed-point log and entropy formats
  localparam int LOG_FRAC_W = 32;
  localparam int LOG_INT_W  = 4;
  localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
  localparam int WEIGHT_W   = VOXEL_W + LOG_W;     // n * log2(n) in Q.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Entropy table read request
  typedef struct packed {
    logic               en;
    logic [VOXEL_W-1:0] addr;
  } rom_rd_t;

  // log2(n) in Q4.32 by repeated squaring of the mantissa; constants only
  function automatic logic [LOG_W-1:0] log2_q32(input logic [VOXEL_W-1:0] n);
    logic [LOG_INT_W-1:0] e;
    logic [63:0]          m;
    logic [LOG_W-1:0]     r;
    e = '0;
    for (int i = 0; i < VOXEL_W; i++) begin
      if (n[i]) e = LOG_INT_W'(i);
    end
    m = (64'(n) << 31) >> e;
    r = {e, {LOG_FRAC_W{1'b0}}};
    for (int b = LOG_FRAC_W - 1; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // full * log2(full), the whole-image weight
  localparam logic [LOG_W-1:0]    FULL_LOG  = log2_q32(FULL_SCALE);
  localparam logic [WEIGHT_W-1:0] WHOLE_Q32 =
    WEIGHT_W'(64'(FULL_SCALE) * 64'(FULL_LOG));

endpackage

[hdl/fia_if.sv]
// Request channels of the fuzziness index accumulator: voxel input and
// result output. Depends on fia_pkg.
`timescale 1ns / 1ps

interface fia_in_if;
  logic                        valid;
  logic                        ready;
  logic [fia_pkg::VOXEL_W-1:0] voxel;
  logic                        last_voxel;

  modport source(output valid, voxel, last_voxel, input ready);
  modport sink(input valid, voxel, last_voxel, output ready);
endinterface

interface fia_out_if;
  logic                          valid;
  logic                          ready;
  logic [fia_pkg::SUPPORT_W-1:0] support_count;
  logic [fia_pkg::ENTROPY_W-1:0] entropy_total;
  logic [fia_pkg::DIST_W-1:0]    distance_total;
  logic [fia_pkg::SQUARE_W-1:0]  square_total;

  modport source(output valid, support_count, entropy_total, distance_total,
                 square_total, input ready);
  modport sink(input valid, support_count, entropy_total, distance_total,
               square_total, output ready);
endinterface

[hdl/fia_entropy_rom.sv]
// Binary-entropy table (nats, Q0.ENT_W) with its own fill engine that
// computes entries 1 to 65533 after reset. Depends on fia_pkg.
`timescale 1ns / 1ps

module fia_entropy_rom (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fia_pkg::rom_rd_t             rd_req,
  output logic [fia_pkg::ENT_W-1:0]    rd_data,
  output logic                         fill_done
);

  localparam int VW        = fia_pkg::VOXEL_W;
  localparam int T_W       = fia_pkg::WEIGHT_W;       // entropy sum in bits, Q.32
  localparam int Q_W       = 33;                      // quotient, up to 2^32
  localparam int CNT_W     = 6;
  localparam int DIV_K     = 15;                      // full scale = 2 * (2^15 - 1)
  localparam int DIV_STEPS = 4;                       // folds that bring t/2 near 2^15
  localparam int ROUND_BIT = 63 - fia_pkg::ENTROPY_FRAC_BITS;
  localparam int ENTRY_LSB = 64 - fia_pkg::ENTROPY_FRAC_BITS;
  localparam logic [Q_W-1:0] B_MAX = Q_W'(64'h1_0000_0000);
  localparam logic [T_W-1:0] DIV_M = T_W'((64'd1 << DIV_K) - 64'd1);
  localparam logic [VW-1:0]  LAST_ADDR = fia_pkg::FULL_SCALE - VW'(1);
  localparam logic [31:0]    LN2_Q32_EXT = fia_pkg::LN2_Q32;

  typedef enum logic [2:0] {
    F_SETUP, F_LOG, F_MUL, F_SUB, F_PRE, F_DIV, F_PROD, F_DONE
  } fill_state_t;

  // Highest set bit
  function automatic logic [fia_pkg::LOG_INT_W-1:0] msb_index(input logic [VW-1:0] n);
    logic [fia_pkg::LOG_INT_W-1:0] e;
    e = '0;
    for (int i = 0; i < VW; i++) begin
      if (n[i]) e = fia_pkg::LOG_INT_W'(i);
    end
    return e;
  endfunction

  logic [fia_pkg::ENT_W-1:0] mem [0:(1 << VW) - 1];
  logic [fia_pkg::ENT_W-1:0] rd_data_r;

  fill_state_t state_r;
  logic [VW-1:0] addr_r;
  logic          wr_en_r;
  logic          done_r;
  logic [CNT_W-1:0] cnt_r;

  // Datapath registers of the fill engine
  logic [31:0]                       mv_r, mw_r, mv_nxt, mw_nxt;
  logic [fia_pkg::LOG_INT_W-1:0]     lv_int_r, lw_int_r, lv_int_nxt, lw_int_nxt;
  logic [fia_pkg::LOG_FRAC_W-1:0]    lv_frac_r, lw_frac_r, lv_frac_nxt, lw_frac_nxt;
  logic [T_W-1:0]                    pv_r, pw_r, pv_nxt, pw_nxt;
  logic [T_W-1:0]                    t_r, t_nxt;
  logic [T_W-1:0]                    rem_r, rem_nxt, quo_r, quo_nxt;
  logic [63:0]                       p_r, p_nxt;
  logic [fia_pkg::ENT_W-1:0]         entry_r, entry_nxt;

  // Combinational helpers
  logic [VW-1:0]  v_w;
  logic [63:0]    sqv, sqw;
  logic [32:0]    sv, sw;
  logic [T_W:0]   parts, whole_ext;
  logic [T_W-1:0] fold_hi, fold_lo;
  logic [Q_W-1:0] b_sel;
  logic [64:0]    rsum;

  assign v_w = fia_pkg::FULL_SCALE - addr_r;

  // Fill datapath: one short step per cycle, selected by the state
  always_comb begin
    mv_nxt      = mv_r;
    mw_nxt      = mw_r;
    lv_int_nxt  = lv_int_r;
    lw_int_nxt  = lw_int_r;
    lv_frac_nxt = lv_frac_r;
    lw_frac_nxt = lw_frac_r;
    pv_nxt      = pv_r;
    pw_nxt      = pw_r;
    t_nxt       = t_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    p_nxt       = p_r;
    entry_nxt   = entry_r;

    sqv       = 64'(mv_r) * 64'(mv_r);
    sqw       = 64'(mw_r) * 64'(mw_r);
    sv        = sqv[63:31];
    sw        = sqw[63:31];
    parts     = (T_W+1)'(pv_r) + (T_W+1)'(pw_r);
    whole_ext = (T_W+1)'(fia_pkg::WHOLE_Q32);
    fold_hi   = rem_r >> DIV_K;
    fold_lo   = rem_r & DIV_M;
    b_sel     = (quo_r > T_W'(B_MAX)) ? B_MAX : quo_r[Q_W-1:0];
    rsum      = 65'(p_r) + (65'(1) << ROUND_BIT);

    case (state_r)
      F_SETUP: begin
        lv_int_nxt  = msb_index(addr_r);
        lw_int_nxt  = msb_index(v_w);
        lv_frac_nxt = '0;
        lw_frac_nxt = '0;
        mv_nxt      = 32'({addr_r, 31'b0} >> lv_int_nxt);
        mw_nxt      = 32'({v_w, 31'b0} >> lw_int_nxt);
      end
      F_LOG: begin
        // one fraction bit of each log per cycle
        if (sv[32]) begin
          mv_nxt = sv[32:1];
          lv_frac_nxt[cnt_r[4:0]] = 1'b1;
        end else begin
          mv_nxt = sv[31:0];
        end
        if (sw[32]) begin
          mw_nxt = sw[32:1];
          lw_frac_nxt[cnt_r[4:0]] = 1'b1;
        end else begin
          mw_nxt = sw[31:0];
        end
      end
      F_MUL: begin
        pv_nxt = T_W'(T_W'(addr_r) * T_W'({lv_int_r, lv_frac_r}));
        pw_nxt = T_W'(T_W'(v_w) * T_W'({lw_int_r, lw_frac_r}));
      end
      F_SUB: begin
        t_nxt = (whole_ext > parts) ? T_W'(whole_ext - parts) : '0;
      end
      F_PRE: begin
        // t / 65534 is (t / 2) / (2^15 - 1)
        rem_nxt = t_r >> 1;
        quo_nxt = '0;
      end
      F_DIV: begin
        if (cnt_r == '0) begin
          // remainder is at most 2^15 - 1 here, one compare and subtract ends it
          if (rem_r >= DIV_M) begin
            rem_nxt = rem_r - DIV_M;
            quo_nxt = quo_r + T_W'(1);
          end
        end else begin
          // hi * 2^15 + lo = hi * (2^15 - 1) + (hi + lo)
          rem_nxt = fold_hi + fold_lo;
          quo_nxt = quo_r + fold_hi;
        end
      end
      F_PROD: begin
        p_nxt = 64'(65'(b_sel) * 65'(LN2_Q32_EXT));
      end
      default: begin
        entry_nxt = rsum[ENTRY_LSB +: fia_pkg::ENT_W];
      end
    endcase
    if (state_r == F_PROD) begin
      entry_nxt = entry_r;
    end
  end

  // Fill sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_SETUP;
      addr_r  <= VW'(1);
      cnt_r   <= '0;
      wr_en_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      wr_en_r <= 1'b0;
      unique case (state_r)
        F_SETUP: begin
          cnt_r   <= CNT_W'(fia_pkg::LOG_FRAC_W - 1);
          state_r <= F_LOG;
        end
        F_LOG: begin
          if (cnt_r == '0) begin
            state_r <= F_MUL;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        F_MUL: state_r <= F_SUB;
        F_SUB: state_r <= F_PRE;
        F_PRE: begin
          cnt_r   <= CNT_W'(DIV_STEPS);
          state_r <= F_DIV;
        end
        F_DIV: begin
          if (cnt_r == '0) begin
            state_r <= F_PROD;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        F_PROD: begin
          // entry is rounded next cycle and written the cycle after
          state_r <= F_DONE;
          done_r  <= 1'b0;
        end
        F_DONE: begin
          if (wr_en_r) begin
            // entry lands at addr_r on this edge
            if (addr_r == LAST_ADDR) begin
              done_r <= 1'b1;
            end else begin
              addr_r  <= addr_r + VW'(1);
              state_r <= F_SETUP;
            end
          end else if (!done_r) begin
            wr_en_r <= 1'b1;
          end
        end
        default: state_r <= F_SETUP;
      endcase
    end
  end

  // Fill datapath registers
  always_ff @(posedge clk) begin
    mv_r      <= mv_nxt;
    mw_r      <= mw_nxt;
    lv_int_r  <= lv_int_nxt;
    lw_int_r  <= lw_int_nxt;
    lv_frac_r <= lv_frac_nxt;
    lw_frac_r <= lw_frac_nxt;
    pv_r      <= pv_nxt;
    pw_r      <= pw_nxt;
    t_r       <= t_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    p_r       <= p_nxt;
    entry_r   <= entry_nxt;
  end

  // Table storage: write from the fill engine, registered read
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem[addr_r] <= entry_r;
    end
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign fill_done = done_r;

endmodule

[hdl/fuzziness_index_accumulator.sv]
// Top level of the fuzziness index accumulator: three-register voxel
// pipeline and running totals. Depends on fia_pkg, fia_if, fia_entropy_rom.
`timescale 1ns / 1ps
//
// Usage
//   in_ch carries one voxel request per cycle (voxel, last_voxel) on a
//   valid/ready handshake; out_ch carries one result request (support
//   count and the entropy, distance and squared-distance totals) for each
//   voxel marked last_voxel, after which all totals restart from zero.
//   Throughput is one voxel per cycle while in_ch.ready is high. The result
//   of a last voxel reaches out_ch through the input register, the
//   table read / term register and the total and output register.
//   After reset the block fills its 65536-entry entropy table, computing
//   entries 1..65533 one after another. in_ch.ready stays low until the
//   fill is done. When the receiver stalls, the output register holds its
//   result; voxels keep flowing until a second last voxel reaches the
//   totals stage, and only then does in_ch.ready drop until out_ch.ready
//   returns. Sums wrap at their widths and never saturate.

module fuzziness_index_accumulator (
  input  logic       clk,
  input  logic       rst_n,
  fia_in_if.sink     in_ch,
  fia_out_if.source  out_ch
);

  localparam int VW = fia_pkg::VOXEL_W;

  // Table read and fill status
  fia_pkg::rom_rd_t          rd_req;
  logic [fia_pkg::ENT_W-1:0] rom_data;
  logic                      table_ready;

  // Stage A: accepted voxel
  logic          a_valid_r;
  logic          a_last_r;
  logic [VW-1:0] a_voxel_r;

  // Stage B: per-voxel terms
  logic                          b_valid_r;
  logic                          b_last_r;
  logic                          b_count_r;
  logic [fia_pkg::ENT_W-1:0]     b_ent_r;
  logic [fia_pkg::HALF_W-1:0]    b_dist_r;
  logic [fia_pkg::HALF_SQ_W-1:0] b_sq_r;

  // Running totals
  logic [fia_pkg::COUNT_BITS-1:0]   cnt_acc_r,  cnt_nxt;
  logic [fia_pkg::ENTROPY_W-1:0]    ent_acc_r,  ent_nxt;
  logic [fia_pkg::DIST_W-1:0]       lin_acc_r,  lin_nxt;
  logic [fia_pkg::SQUARE_ACC_W-1:0] sq_acc_r,   sq_nxt;

  // Output register
  logic                          out_valid_r;
  logic [fia_pkg::SUPPORT_W-1:0] out_cnt_r;
  logic [fia_pkg::ENTROPY_W-1:0] out_ent_r;
  logic [fia_pkg::DIST_W-1:0]    out_lin_r;
  logic [fia_pkg::SQUARE_W-1:0]  out_sq_r;

  logic                          adv;
  logic                          in_fire;
  logic                          a_nonzero, a_term;
  logic [VW-1:0]                 a_comp;
  logic [fia_pkg::HALF_W-1:0]    a_dist;
  logic [fia_pkg::HALF_SQ_W-1:0] a_sq;

  // Pipeline moves unless a result would overwrite an untaken one
  assign adv     = !(b_valid_r && b_last_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = adv && table_ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign rd_req.en   = adv;
  assign rd_req.addr = in_ch.voxel;

  fia_entropy_rom u_rom (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_req    (rd_req),
    .rd_data   (rom_data),
    .fill_done (table_ready)
  );

  // Terms of one voxel: distance to the nearer end and its square
  assign a_nonzero = a_voxel_r != '0;
  assign a_term    = a_nonzero && (a_voxel_r < fia_pkg::FULL_SCALE);
  assign a_comp    = fia_pkg::FULL_SCALE - a_voxel_r;
  assign a_dist    = (a_voxel_r <= a_comp) ? a_voxel_r[fia_pkg::HALF_W-1:0]
                                           : a_comp[fia_pkg::HALF_W-1:0];
  assign a_sq      = fia_pkg::HALF_SQ_W'(a_dist) * fia_pkg::HALF_SQ_W'(a_dist);

  // Totals including the voxel in stage B
  assign cnt_nxt = cnt_acc_r + fia_pkg::COUNT_BITS'(b_count_r);
  assign ent_nxt = ent_acc_r + fia_pkg::ENTROPY_W'(b_ent_r);
  assign lin_nxt = lin_acc_r + fia_pkg::DIST_W'(b_dist_r);
  assign sq_nxt  = sq_acc_r + fia_pkg::SQUARE_ACC_W'(b_sq_r);

  // Control state and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_acc_r   <= '0;
      ent_acc_r   <= '0;
      lin_acc_r   <= '0;
      sq_acc_r    <= '0;
    end else begin
      // a new result replaces the one taken this cycle, if one was held
      if (adv && b_valid_r && b_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        a_valid_r <= in_fire;
        b_valid_r <= a_valid_r;
        if (b_valid_r) begin
          if (b_last_r) begin
            cnt_acc_r   <= '0;
            ent_acc_r   <= '0;
            lin_acc_r   <= '0;
            sq_acc_r    <= '0;
          end else begin
            cnt_acc_r <= cnt_nxt;
            ent_acc_r <= ent_nxt;
            lin_acc_r <= lin_nxt;
            sq_acc_r  <= sq_nxt;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_voxel_r <= in_ch.voxel;
      a_last_r  <= in_ch.last_voxel;
      b_last_r  <= a_last_r;
      b_count_r <= a_nonzero;
      b_ent_r   <= a_term ? rom_data : '0;
      b_dist_r  <= a_term ? a_dist : '0;
      b_sq_r    <= a_term ? a_sq : '0;
      if (b_valid_r && b_last_r) begin
        out_cnt_r <= fia_pkg::SUPPORT_W'(cnt_nxt);
        out_ent_r <= ent_nxt;
        out_lin_r <= lin_nxt;
        out_sq_r  <= sq_nxt[fia_pkg::SQUARE_W-1:0];
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.support_count  = out_cnt_r;
  assign out_ch.entropy_total  = out_ent_r;
  assign out_ch.distance_total = out_lin_r;
  assign out_ch.square_total   = out_sq_r;

endmodule
